### hw/rtl/bblur_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the divide helper of the 3x3 box blur.
package bblur_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CH_N  = 3;
    localparam int CH_W  = 8;
    localparam int PIX_W = CH_N * CH_W;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam int            WIDTH_RESET  = 1024;
    localparam logic [15:0]   HEIGHT_RESET = 16'd768;

    // column sum of up to 3 pixels, window sum of up to 9, numerator 2*sum+cnt
    localparam int CSUM_W    = 10;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = 13;
    localparam int MAG_W     = 20;
    localparam int DIV_SHIFT = 20;
    localparam int PROD_W    = NUM_W + MAG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL_A,
        S_COL_B,
        S_COL_C,
        S_PREP,
        S_SEND
    } t_state;

    // ceil(2^20 / (2*cnt)); exact floor division for numerators below 2^16
    function automatic logic [MAG_W-1:0] div_magic(input logic [CNT_W-1:0] cnt);
        logic [MAG_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = 20'd0;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/bblur_row_store.sv
`timescale 1ns / 1ps
// Row store: single-port-write, single-port-read RAM with registered read data.
module bblur_row_store #(
    parameter int DEPTH  = 3 * bblur_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [bblur_pkg::PIX_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [bblur_pkg::PIX_W-1:0] o_rdata
);

    logic [bblur_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [bblur_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/box_blur_3x3_edge_averaged.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 box blur with border-averaged means.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_action, i_in_red/green/blue
//  output  | out       | o_out_valid / i_out_ready  | o_out_red/green/blue, o_run_last,
//          |           |                            | o_frame_end
//  config  | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A pixel of row 0 is only stored; a later pixel yields up to two results. A drain
// computes up to two column sums for column 0, one for middle columns, none for the last.
// The pace is set by the single read port of the row store: each column sum
// needs two reads, and each result passes a prepare and a send state.
// Reset is synchronous; the row store has no clearing pass. A full output
// register stalls the sequencer in its send cycle only.
module box_blur_3x3_edge_averaged #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [7:0]                       i_in_red,
    input  logic [7:0]                       i_in_green,
    input  logic [7:0]                       i_in_blue,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_red,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_blue,
    output logic                             o_run_last,
    output logic                             o_frame_end,

    input  logic                             i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_N      = bblur_pkg::CH_N;
    localparam int CH_W      = bblur_pkg::CH_W;
    localparam int PIX_W     = bblur_pkg::PIX_W;
    localparam int COL_W     = bblur_pkg::COL_W;
    localparam int ROW_W     = bblur_pkg::ROW_W;
    localparam int CSUM_W    = bblur_pkg::CSUM_W;
    localparam int SUM_W     = bblur_pkg::SUM_W;
    localparam int CNT_W     = bblur_pkg::CNT_W;
    localparam int NUM_W     = bblur_pkg::NUM_W;
    localparam int MAG_W     = bblur_pkg::MAG_W;
    localparam int PROD_W    = bblur_pkg::PROD_W;
    localparam int DIV_SHIFT = bblur_pkg::DIV_SHIFT;

    localparam int DEPTH  = 3 * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * MAX_WIDTH);

    localparam logic [COL_W-1:0] WIDTH_RST =
        COL_W'((MAX_WIDTH < bblur_pkg::WIDTH_RESET) ? MAX_WIDTH : bblur_pkg::WIDTH_RESET);

    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] s);
        logic [ADDR_W-1:0] b;
        case (s)
            2'd1:    b = BASE1;
            2'd2:    b = BASE2;
            default: b = '0;
        endcase
        return b;
    endfunction

    // control state
    bblur_pkg::t_state r_state, n_state;
    logic [COL_W-1:0]  r_width, n_width;
    logic [ROW_W-1:0]  r_height, n_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [1:0]        r_slot, n_slot;
    logic              r_done, n_done;
    logic [COL_W-1:0]  r_dcol, n_dcol;
    logic              r_out_valid, n_out_valid;

    // job and datapath registers
    logic [1:0]        r_last_slot, n_last_slot;
    logic              r_drain, n_drain;
    logic [COL_W-1:0]  r_rd_col, n_rd_col;
    logic [1:0]        r_slot_a, n_slot_a;
    logic [1:0]        r_slot_b, n_slot_b;
    logic              r_use_b, n_use_b;
    logic              r_ge1, n_ge1;
    logic              r_ge2, n_ge2;
    logic              r_two, n_two;
    logic              r_next, n_next;
    logic              r_fend, n_fend;
    logic              r_first, n_first;
    logic              r_k, n_k;
    logic [CH_N-1:0][CSUM_W-1:0] r_acc, n_acc;
    logic [CH_N-1:0][CSUM_W-1:0] r_cs, n_cs;
    logic [CH_N-1:0][CSUM_W-1:0] r_wa, n_wa;
    logic [CH_N-1:0][CSUM_W-1:0] r_wb, n_wb;
    logic [CH_N-1:0][NUM_W-1:0]  r_num, n_num;
    logic [MAG_W-1:0]            r_mag, n_mag;
    logic              r_last, n_last;
    logic              r_fe, n_fe;
    logic [CH_N-1:0][CH_W-1:0]   r_out_pix, n_out_pix;
    logic              r_run_last, n_run_last;
    logic              r_frame_end, n_frame_end;

    // combinational helpers
    logic [CH_N-1:0][CH_W-1:0]   pix_in;
    logic [CH_N-1:0][CH_W-1:0]   rd_pix;
    logic [PIX_W-1:0]            mem_rdata;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [COL_W-1:0]            e_col;
    logic [ROW_W-1:0]            e_row;
    logic [1:0]                  e_slot;
    logic                        col_last;
    logic                        row_last;
    logic [CH_N-1:0][CSUM_W-1:0] cs_fin;
    logic [CH_N-1:0][SUM_W-1:0]  sum;
    logic [CH_N-1:0][PROD_W-1:0] prod;
    logic [1:0]                  nr;
    logic [1:0]                  nc;
    logic [CNT_W-1:0]            cnt;
    logic                        res_last;
    logic                        res_fe;
    logic [COL_W-1:0]            cfg_w;
    logic [COL_W-1:0]            cfg_w_clamp;
    logic [ROW_W-1:0]            cfg_h_clamp;

    assign pix_in = {i_in_red, i_in_green, i_in_blue};
    assign rd_pix = mem_rdata;

    bblur_row_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (pix_in),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // position of the pixel being accepted; a finished frame restarts at the origin
    always_comb begin
        e_col    = r_done ? '0 : r_col;
        e_row    = r_done ? '0 : r_row;
        e_slot   = r_done ? 2'd0 : r_slot;
        col_last = (e_col == r_width - COL_W'(1));
        row_last = (e_row == r_height - ROW_W'(1));
    end

    always_comb begin
        cfg_w = i_cfg_data[COL_W-1:0];
        if (cfg_w == '0) begin
            cfg_w_clamp = COL_W'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            cfg_w_clamp = COL_W'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = cfg_w;
        end
        cfg_h_clamp = (i_cfg_data == '0) ? ROW_W'(1) : i_cfg_data;
    end

    // column sum, window sum and divisor of the result being prepared
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            cs_fin[c] = r_acc[c] + (r_use_b ? CSUM_W'(rd_pix[c]) : CSUM_W'(0));
            if (r_drain) begin
                sum[c] = SUM_W'(r_ge1 ? r_wa[c] : CSUM_W'(0)) + SUM_W'(r_wb[c])
                       + SUM_W'(r_next ? r_cs[c] : CSUM_W'(0));
            end else if (!r_k) begin
                sum[c] = SUM_W'(r_ge2 ? r_wa[c] : CSUM_W'(0)) + SUM_W'(r_wb[c])
                       + SUM_W'(r_cs[c]);
            end else begin
                sum[c] = SUM_W'(r_ge1 ? r_wb[c] : CSUM_W'(0)) + SUM_W'(r_cs[c]);
            end
            prod[c] = PROD_W'(r_num[c]) * PROD_W'(r_mag);
        end
        if (r_drain) begin
            nr       = r_use_b ? 2'd2 : 2'd1;
            nc       = 2'd1 + {1'b0, r_ge1} + {1'b0, r_next};
            res_last = 1'b1;
            res_fe   = r_fend;
        end else if (!r_k) begin
            nr       = r_use_b ? 2'd3 : 2'd2;
            nc       = r_ge2 ? 2'd3 : 2'd2;
            res_last = !r_two;
            res_fe   = 1'b0;
        end else begin
            nr       = r_use_b ? 2'd3 : 2'd2;
            nc       = r_ge1 ? 2'd2 : 2'd1;
            res_last = 1'b1;
            res_fe   = 1'b0;
        end
        cnt = {2'b00, nr} * {2'b00, nc};
    end

    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_col       = r_col;
        n_row       = r_row;
        n_slot      = r_slot;
        n_done      = r_done;
        n_dcol      = r_dcol;
        n_out_valid = r_out_valid;
        n_last_slot = r_last_slot;
        n_drain     = r_drain;
        n_rd_col    = r_rd_col;
        n_slot_a    = r_slot_a;
        n_slot_b    = r_slot_b;
        n_use_b     = r_use_b;
        n_ge1       = r_ge1;
        n_ge2       = r_ge2;
        n_two       = r_two;
        n_next      = r_next;
        n_fend      = r_fend;
        n_first     = r_first;
        n_k         = r_k;
        n_acc       = r_acc;
        n_cs        = r_cs;
        n_wa        = r_wa;
        n_wb        = r_wb;
        n_num       = r_num;
        n_mag       = r_mag;
        n_last      = r_last;
        n_fe        = r_fe;
        n_out_pix   = r_out_pix;
        n_run_last  = r_run_last;
        n_frame_end = r_frame_end;

        mem_we    = 1'b0;
        mem_waddr = slot_base(e_slot) + ADDR_W'(e_col);
        mem_raddr = slot_base(r_slot_a) + ADDR_W'(r_rd_col);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bblur_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == bblur_pkg::ACT_PIXEL) begin
                        mem_we = 1'b1;
                        n_done = 1'b0;
                        if (col_last) begin
                            n_col = '0;
                            if (row_last) begin
                                n_row       = '0;
                                n_slot      = 2'd0;
                                n_done      = 1'b1;
                                n_dcol      = '0;
                                n_last_slot = e_slot;
                            end else begin
                                n_row  = e_row + ROW_W'(1);
                                n_slot = slot_next(e_slot);
                            end
                        end else begin
                            n_col = e_col + COL_W'(1);
                            n_row = e_row;
                            n_slot = e_slot;
                        end
                        // rows 1 and up produce results for the row above
                        if (e_row != '0) begin
                            n_drain  = 1'b0;
                            n_slot_a = slot_prev(e_slot);
                            n_slot_b = slot_prev(slot_prev(e_slot));
                            n_use_b  = (e_row > ROW_W'(1));
                            n_rd_col = e_col;
                            n_ge1    = (e_col != '0);
                            n_ge2    = (e_col > COL_W'(1));
                            n_two    = col_last;
                            n_k      = (e_col == '0);
                            n_next   = 1'b0;
                            n_fend   = 1'b0;
                            n_first  = 1'b0;
                            for (int c = 0; c < CH_N; c++) begin
                                n_acc[c] = CSUM_W'(pix_in[c]);
                            end
                            n_state = bblur_pkg::S_COL_A;
                        end
                    end else if (r_done && (r_dcol < r_width)) begin
                        n_dcol   = r_dcol + COL_W'(1);
                        n_drain  = 1'b1;
                        n_slot_a = r_last_slot;
                        n_slot_b = slot_prev(r_last_slot);
                        n_use_b  = (r_height != ROW_W'(1));
                        n_ge1    = (r_dcol != '0);
                        n_ge2    = 1'b0;
                        n_two    = 1'b0;
                        n_k      = 1'b0;
                        n_next   = (r_dcol != r_width - COL_W'(1));
                        n_fend   = (r_dcol == r_width - COL_W'(1));
                        n_first  = (r_dcol == '0);
                        n_acc    = '0;
                        if (r_dcol == '0) begin
                            n_rd_col = '0;
                            n_state  = bblur_pkg::S_COL_A;
                        end else if (r_dcol != r_width - COL_W'(1)) begin
                            n_rd_col = r_dcol + COL_W'(1);
                            n_state  = bblur_pkg::S_COL_A;
                        end else begin
                            n_state = bblur_pkg::S_PREP;
                        end
                    end
                end
            end

            bblur_pkg::S_COL_A: begin
                mem_raddr = slot_base(r_slot_a) + ADDR_W'(r_rd_col);
                n_state   = bblur_pkg::S_COL_B;
            end

            bblur_pkg::S_COL_B: begin
                mem_raddr = slot_base(r_slot_b) + ADDR_W'(r_rd_col);
                for (int c = 0; c < CH_N; c++) begin
                    n_acc[c] = r_acc[c] + CSUM_W'(rd_pix[c]);
                end
                n_state = bblur_pkg::S_COL_C;
            end

            bblur_pkg::S_COL_C: begin
                if (r_drain && r_first) begin
                    // first drain of a frame: column 0 seeds the window
                    n_wb    = cs_fin;
                    n_first = 1'b0;
                    if (r_next) begin
                        n_rd_col = COL_W'(1);
                        n_acc    = '0;
                        n_state  = bblur_pkg::S_COL_A;
                    end else begin
                        n_state = bblur_pkg::S_PREP;
                    end
                end else begin
                    n_cs = cs_fin;
                    if (!r_drain && !r_ge1 && !r_two) begin
                        n_wa    = r_wb;
                        n_wb    = cs_fin;
                        n_state = bblur_pkg::S_IDLE;
                    end else begin
                        n_state = bblur_pkg::S_PREP;
                    end
                end
            end

            bblur_pkg::S_PREP: begin
                for (int c = 0; c < CH_N; c++) begin
                    n_num[c] = {sum[c], 1'b0} + NUM_W'(cnt);
                end
                n_mag   = bblur_pkg::div_magic(cnt);
                n_last  = res_last;
                n_fe    = res_fe;
                n_state = bblur_pkg::S_SEND;
            end

            bblur_pkg::S_SEND: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    for (int c = 0; c < CH_N; c++) begin
                        n_out_pix[c] = prod[c][DIV_SHIFT+CH_W-1:DIV_SHIFT];
                    end
                    n_run_last  = r_last;
                    n_frame_end = r_fe;
                    if (!r_drain && !r_k && r_two) begin
                        n_k     = 1'b1;
                        n_state = bblur_pkg::S_PREP;
                    end else begin
                        if (!r_drain || r_next) begin
                            n_wa = r_wb;
                            n_wb = r_cs;
                        end
                        n_state = bblur_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = bblur_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                bblur_pkg::CFG_FRAME_WIDTH: begin
                    n_width = cfg_w_clamp;
                    n_col   = '0;
                    n_row   = '0;
                    n_slot  = 2'd0;
                    n_dcol  = '0;
                    n_done  = 1'b0;
                end
                bblur_pkg::CFG_FRAME_HEIGHT: begin
                    n_height = cfg_h_clamp;
                    n_col    = '0;
                    n_row    = '0;
                    n_slot   = 2'd0;
                    n_dcol   = '0;
                    n_done   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bblur_pkg::S_IDLE;
            r_width     <= WIDTH_RST;
            r_height    <= bblur_pkg::HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= 2'd0;
            r_done      <= 1'b0;
            r_dcol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_slot      <= n_slot;
            r_done      <= n_done;
            r_dcol      <= n_dcol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_slot <= n_last_slot;
        r_drain     <= n_drain;
        r_rd_col    <= n_rd_col;
        r_slot_a    <= n_slot_a;
        r_slot_b    <= n_slot_b;
        r_use_b     <= n_use_b;
        r_ge1       <= n_ge1;
        r_ge2       <= n_ge2;
        r_two       <= n_two;
        r_next      <= n_next;
        r_fend      <= n_fend;
        r_first     <= n_first;
        r_k         <= n_k;
        r_acc       <= n_acc;
        r_cs        <= n_cs;
        r_wa        <= n_wa;
        r_wb        <= n_wb;
        r_num       <= n_num;
        r_mag       <= n_mag;
        r_last      <= n_last;
        r_fe        <= n_fe;
        r_out_pix   <= n_out_pix;
        r_run_last  <= n_run_last;
        r_frame_end <= n_frame_end;
    end

    assign o_in_ready  = (r_state == bblur_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix[2];
    assign o_out_green = r_out_pix[1];
    assign o_out_blue  = r_out_pix[0];
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

endmodule

### bench/tb_box_blur_3x3_edge_averaged.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 box blur: directed table, extreme frame sizes, then random frames.
module tb_box_blur_3x3_edge_averaged;
    import bblur_pkg::*;

    localparam int MAX_W      = MAX_WIDTH_DEF;
    localparam int RAND_ITEMS = 1200;
    localparam int SETTLE_CYC = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_last;
        logic       frame_end;
    } blur_px_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  act;
        logic [23:0]           px;
        bit                    typed;
        int                    n_typed;
        blur_px_t              t0;
        blur_px_t              t1;
    } stim_row_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_action    = ACT_PIXEL;
    logic [7:0]            i_in_red    = 8'd0;
    logic [7:0]            i_in_green  = 8'd0;
    logic [7:0]            i_in_blue   = 8'd0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic                  o_run_last;
    logic                  o_frame_end;

    box_blur_3x3_edge_averaged uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [23:0] px_rows [3*MAX_W];
    int unsigned next_col, next_row, drain_col;
    bit          frame_done;
    logic [10:0] width_reg;
    logic [15:0] height_reg;

    blur_px_t pending_px [$];
    blur_px_t want_px;
    int       fail_cnt      = 0;
    int       in_gap_pct    = 15;
    int       out_stall_pct = 47;

    function automatic int unsigned eff_w();
        if (width_reg == 11'd0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 16'd0) ? 1 : height_reg;
    endfunction

    function automatic void restart_frame();
        next_col   = 0;
        next_row   = 0;
        drain_col  = 0;
        frame_done = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH) width_reg = data[10:0];
        else height_reg = data;
        restart_frame();
    endfunction

    // rounded-half-up mean over the in-frame part of the 3x3 window
    function automatic blur_px_t blur_at(int r, int c, bit last, bit fend);
        int w, h, cnt, rr, cc, dr, dc;
        int sum_r, sum_g, sum_b;
        logic [23:0] p;
        blur_px_t o;
        w = eff_w();
        h = eff_h();
        cnt = 0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                    p = px_rows[(rr % 3) * MAX_W + cc];
                    sum_r += p[23:16];
                    sum_g += p[15:8];
                    sum_b += p[7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        o.red       = 8'((2 * sum_r + cnt) / (2 * cnt));
        o.green     = 8'((2 * sum_g + cnt) / (2 * cnt));
        o.blue      = 8'((2 * sum_b + cnt) / (2 * cnt));
        o.run_last  = last;
        o.frame_end = fend;
        return o;
    endfunction

    function automatic void blur_step(input logic act, input logic [23:0] px,
                                      output int n, output blur_px_t res [2]);
        int unsigned w, h, r, c;
        bit two;
        w = eff_w();
        h = eff_h();
        n = 0;
        if (act == ACT_DRAIN) begin
            if (frame_done && drain_col < w) begin
                res[0] = blur_at(h - 1, drain_col, 1'b1, drain_col == w - 1);
                drain_col++;
                n = 1;
            end
            return;
        end
        if (frame_done) restart_frame();
        if (next_col >= w) next_col = 0;
        if (next_row >= h) next_row = 0;
        r = next_row;
        c = next_col;
        px_rows[(r % 3) * MAX_W + c] = px;
        if (r >= 1) begin
            two = (c == w - 1);
            if (c >= 1) begin
                res[n] = blur_at(r - 1, c - 1, !two, 1'b0);
                n++;
            end
            if (two) begin
                res[n] = blur_at(r - 1, w - 1, 1'b1, 1'b0);
                n++;
            end
        end
        if (c + 1 >= w) begin
            next_col = 0;
            if (r + 1 >= h) begin
                next_row   = 0;
                frame_done = 1'b1;
                drain_col  = 0;
            end else begin
                next_row = r + 1;
            end
        end else begin
            next_col = c + 1;
        end
    endfunction

    function automatic logic [23:0] rand_px();
        logic [23:0] p;
        int k;
        p = 24'($urandom);
        // bias toward saturated channels now and then
        for (k = 0; k < 3; k++) begin
            if ($urandom_range(9) < 3) p[k*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic stim_row_t row_px(logic act, logic [23:0] px);
        stim_row_t s;
        s = '{default: '0};
        s.act = act;
        s.px  = px;
        return s;
    endfunction

    function automatic stim_row_t row_typed(logic act, logic [23:0] px, int n,
                                            blur_px_t t0, blur_px_t t1);
        stim_row_t s;
        s = row_px(act, px);
        s.typed   = 1'b1;
        s.n_typed = n;
        s.t0      = t0;
        s.t1      = t1;
        return s;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // output side: random stalls and in-order compare
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_px.size() == 0) begin
                $error("output transaction with nothing expected: r=%0d g=%0d b=%0d",
                       o_out_red, o_out_green, o_out_blue);
                fail_cnt++;
            end else begin
                want_px = pending_px.pop_front();
                check_field("out_red", want_px.red, o_out_red);
                check_field("out_green", want_px.green, o_out_green);
                check_field("out_blue", want_px.blue, o_out_blue);
                check_field("run_last", 8'(want_px.run_last), 8'(o_run_last));
                check_field("frame_end", 8'(want_px.frame_end), 8'(o_frame_end));
            end
        end
    end

    task automatic send_item(input stim_row_t row, output int n);
        blur_px_t res [2];
        int k;
        if ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_action   <= row.act;
        i_in_red   <= row.px[23:16];
        i_in_green <= row.px[15:8];
        i_in_blue  <= row.px[7:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        blur_step(row.act, row.px, n, res);
        if (row.typed) begin
            if (row.n_typed > 0) pending_px.push_back(row.t0);
            if (row.n_typed > 1) pending_px.push_back(row.t1);
        end else begin
            for (k = 0; k < n; k++) pending_px.push_back(res[k]);
        end
    endtask

    // hold input off until every expected result is out, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        stim_row_t dir_rows [$];
        int n;
        blur_px_t none;
        none = '0;
        // 1x1 frame: width and height of zero clamp to one
        dir_rows.push_back(row_cfg(CFG_FRAME_WIDTH, 16'd0));
        dir_rows.push_back(row_cfg(CFG_FRAME_HEIGHT, 16'd0));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'hFF0080, 0, none, none));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 1,
                                     {8'd255, 8'd0, 8'd128, 1'b1, 1'b1}, none));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'h00FF01, 0, none, none));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 1,
                                     {8'd0, 8'd255, 8'd1, 1'b1, 1'b1}, none));
        // 2x2 frame, every sum is 510 over 4: rounds half up to 128
        dir_rows.push_back(row_cfg(CFG_FRAME_WIDTH, 16'd2));
        dir_rows.push_back(row_cfg(CFG_FRAME_HEIGHT, 16'd2));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'h00FF00, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'hFF00FF, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'hFF0000, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, 24'h00FFFF, 2,
                                     {8'd128, 8'd128, 8'd128, 1'b0, 1'b0},
                                     {8'd128, 8'd128, 8'd128, 1'b1, 1'b0}));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 1,
                                     {8'd128, 8'd128, 8'd128, 1'b1, 1'b0}, none));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 1,
                                     {8'd128, 8'd128, 8'd128, 1'b1, 1'b1}, none));
        dir_rows.push_back(row_typed(ACT_DRAIN, 24'h0, 0, none, none));
        // new frame on a pixel after completion; undrained last row is dropped
        repeat (4) dir_rows.push_back(row_px(ACT_PIXEL, rand_px()));
        dir_rows.push_back(row_px(ACT_DRAIN, rand_px()));
        dir_rows.push_back(row_px(ACT_PIXEL, rand_px()));
        // one pixel wide: last column gives only the trailing result
        dir_rows.push_back(row_cfg(CFG_FRAME_WIDTH, 16'd1));
        dir_rows.push_back(row_cfg(CFG_FRAME_HEIGHT, 16'd3));
        dir_rows.push_back(row_typed(ACT_PIXEL, {8'd10, 8'd20, 8'd30}, 0, none, none));
        dir_rows.push_back(row_typed(ACT_PIXEL, {8'd11, 8'd21, 8'd31}, 1,
                                     {8'd11, 8'd21, 8'd31, 1'b1, 1'b0}, none));
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                settle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_item(dir_rows[k], n);
            end
        end
    endtask

    task automatic run_extremes();
        int k, n;
        // width field all ones clamps to the full line store
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        for (k = 0; k < 2 * MAX_W; k++) send_item(row_px(ACT_PIXEL, rand_px()), n);
        for (k = 0; k <= MAX_W; k++) send_item(row_px(ACT_DRAIN, rand_px()), n);
        // tallest frame: never completes here, drains give nothing
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        for (k = 0; k < 12; k++) send_item(row_px(ACT_PIXEL, rand_px()), n);
        for (k = 0; k < 3; k++) send_item(row_px(ACT_DRAIN, rand_px()), n);
    endtask

    task automatic run_random();
        int done_items, w, h, ew, eh, stop_at, n, k, n_drain;
        bit need_cfg;
        done_items = 0;
        need_cfg   = 1'b1;
        w = 1;
        h = 1;
        while (done_items < RAND_ITEMS) begin
            if (done_items < RAND_ITEMS / 3) begin
                in_gap_pct    = 15;
                out_stall_pct = 47;
            end else if (done_items < 2 * RAND_ITEMS / 3) begin
                in_gap_pct    = 47;
                out_stall_pct = 15;
            end else begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            if (need_cfg || $urandom_range(99) < 70) begin
                settle();
                w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
                h = $urandom_range(5);
                write_reg(CFG_FRAME_WIDTH, {5'($urandom), 11'(w)});
                write_reg(CFG_FRAME_HEIGHT, 16'(h));
            end
            ew = (w == 0) ? 1 : w;
            eh = (h == 0) ? 1 : h;
            // occasionally cut the frame short; a fresh config restarts it
            stop_at  = ($urandom_range(9) == 0) ? $urandom_range(ew * eh - 1) : ew * eh;
            need_cfg = (stop_at < ew * eh);
            for (k = 0; k < stop_at; k++) begin
                if ($urandom_range(9) == 0) send_item(row_px(ACT_DRAIN, rand_px()), n);
                send_item(row_px(ACT_PIXEL, rand_px()), n);
                done_items++;
            end
            if (!need_cfg) begin
                n_drain = ($urandom_range(4) == 0) ? $urandom_range(ew - 1)
                                                   : ew + $urandom_range(2);
                for (k = 0; k < n_drain; k++) begin
                    send_item(row_px(ACT_DRAIN, rand_px()), n);
                    done_items += n;
                end
            end
        end
    endtask

    initial begin
        width_reg  = 11'(WIDTH_RESET);
        height_reg = HEIGHT_RESET;
        restart_frame();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_extremes();
        run_random();
        settle();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
